// ----- hdl/assert_macros.svh -----
// assertion macros shared by the parser modules
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define QSLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from a condition to a property in the same cycle
`define QSLP_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// implication from a condition to a property in the next cycle
`define QSLP_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hdl/qslp_pkg.sv -----
// shared types, codes and helpers for the quoted string list parser
// no dependencies
`default_nettype none

package qslp_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    MODE_OPEN   = 3'd0,
    MODE_LIST   = 3'd1,
    MODE_STRING = 3'd2,
    MODE_CLOSED = 3'd3,
    MODE_REJECT = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END     = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  localparam logic [7:0] ChOpen   = 8'h5B;  // '['
  localparam logic [7:0] ChClose  = 8'h5D;  // ']'
  localparam logic [7:0] ChComma  = 8'h2C;  // ','
  localparam logic [7:0] ChEscape = 8'h5C;  // backslash
  localparam logic [7:0] ChSingle = 8'h27;  // single quote
  localparam logic [7:0] ChDouble = 8'h22;  // double quote
  localparam logic [7:0] ChNul    = 8'h00;

  // one classified input byte: an optional content or string end result,
  // then an optional verdict
  typedef struct packed {
    logic       has_data;
    kind_e      data_kind;
    logic [7:0] data_value;
    logic       has_verdict;
    logic       verdict_acc;
  } event_t;

  // space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

// ----- hdl/qslp_front.sv -----
// front end: accepts text bytes, tracks the parse mode, classifies each beat
// depends on qslp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module qslp_front import qslp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       final_req_i,
  input  wire logic       q_full_i,
  output      logic       full,
  output      logic       ev_wr_o,
  output      event_t     ev_o
);

  mode_e mode_q, mode_d;
  logic  dq_q, dq_d;
  logic  esc_q, esc_d;
  logic  ended_q, ended_d;
  logic  acc;
  logic  live;
  logic  is_nul;
  logic  close_hit;

  assign full      = q_full_i;
  assign acc       = push && !full;
  assign live      = acc && !ended_q;
  assign is_nul    = (text_byte_i == ChNul);
  assign close_hit = (text_byte_i == (dq_q ? ChDouble : ChSingle));

  // next parse state
  always_comb begin
    mode_d  = mode_q;
    dq_d    = dq_q;
    esc_d   = esc_q;
    ended_d = ended_q;
    if (live) begin
      if (!is_nul) begin
        case (mode_q)
          MODE_OPEN: begin
            if (text_byte_i == ChOpen) mode_d = MODE_LIST;
            else if (!is_blank(text_byte_i)) mode_d = MODE_REJECT;
          end
          MODE_LIST: begin
            if (text_byte_i == ChClose) begin
              mode_d = MODE_CLOSED;
            end else if ((text_byte_i == ChSingle) || (text_byte_i == ChDouble)) begin
              mode_d = MODE_STRING;
              dq_d   = (text_byte_i == ChDouble);
              esc_d  = 1'b0;
            end else if ((text_byte_i != ChComma) && !is_blank(text_byte_i)) begin
              mode_d = MODE_REJECT;
            end
          end
          MODE_STRING: begin
            if (esc_q) esc_d = 1'b0;
            else if (text_byte_i == ChEscape) esc_d = 1'b1;
            else if (close_hit) mode_d = MODE_LIST;
          end
          MODE_CLOSED: begin
            if (!is_blank(text_byte_i)) mode_d = MODE_REJECT;
          end
          default: mode_d = MODE_REJECT;
        endcase
      end
      if (is_nul || final_req_i) ended_d = 1'b1;
    end
  end

  // classified event for the back end
  always_comb begin
    ev_o             = '0;
    ev_o.data_kind   = KIND_BYTE;
    ev_o.data_value  = text_byte_i;
    if (!is_nul && (mode_q == MODE_STRING)) begin
      if (esc_q) begin
        ev_o.has_data = 1'b1;
      end else if (close_hit) begin
        ev_o.has_data   = 1'b1;
        ev_o.data_kind  = KIND_END;
        ev_o.data_value = '0;
      end else if (text_byte_i != ChEscape) begin
        ev_o.has_data = 1'b1;
      end
    end
    ev_o.has_verdict = is_nul || final_req_i;
    ev_o.verdict_acc = (mode_d == MODE_CLOSED);
    ev_wr_o          = live && (ev_o.has_data || ev_o.has_verdict);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OPEN;
      dq_q    <= 1'b0;
      esc_q   <= 1'b0;
      ended_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      dq_q    <= dq_d;
      esc_q   <= esc_d;
      ended_q <= ended_d;
    end
  end

  `QSLP_ASSERT_NXT(a_ended_sticky, ended_q, ended_q, "text end flag dropped")
  `QSLP_ASSERT_IMP(a_no_event_after_end, ended_q, !ev_wr_o, "event after verdict")
  `QSLP_ASSERT_IMP(a_esc_only_in_string, esc_q, mode_q == MODE_STRING, "escape outside string")

endmodule

`default_nettype wire

// ----- hdl/qslp_evq.sv -----
// short event queue between the front and back ends
// depends on qslp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module qslp_evq import qslp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   wr_i,
  input  wire event_t wr_data_i,
  output      logic   full_o,
  input  wire logic   rd_i,
  output      logic   valid_o,
  output      event_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  event_t          slot_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = slot_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) slot_q[wp_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  `QSLP_ASSERT(a_cnt_bound, cnt_q <= CntFull, "queue count above depth")
  `QSLP_ASSERT_IMP(a_no_wr_full, full_o, !wr_i, "write into full queue")

endmodule

`default_nettype wire

// ----- hdl/qslp_back.sv -----
// back end: expands each queued event into one or two result beats
// depends on qslp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module qslp_back import qslp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire event_t     q_data_i,
  output      logic       q_rd_o,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [1:0] kind_o,
  output      logic [7:0] value_o,
  output      logic       accepted_o,
  output      logic       last_of_run_o
);

  logic   cur_valid_q;
  event_t cur_q;
  logic   take;
  logic   popped;
  logic   last_beat;

  assign empty     = !cur_valid_q;
  assign popped    = pop && cur_valid_q;
  assign last_beat = !cur_q.has_data || !cur_q.has_verdict;
  assign take      = q_valid_i && (!cur_valid_q || (popped && last_beat));
  assign q_rd_o    = take;

  // result fields from the held event: data beat first, verdict after it
  always_comb begin
    if (cur_q.has_data) begin
      kind_o        = cur_q.data_kind;
      value_o       = cur_q.data_value;
      accepted_o    = 1'b0;
      last_of_run_o = !cur_q.has_verdict;
    end else begin
      kind_o        = KIND_VERDICT;
      value_o       = '0;
      accepted_o    = cur_q.verdict_acc;
      last_of_run_o = 1'b1;
    end
  end

  // held event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
    end else if (take) begin
      cur_valid_q <= 1'b1;
      cur_q       <= q_data_i;
    end else if (popped) begin
      if (last_beat) cur_valid_q <= 1'b0;
      else cur_q.has_data <= 1'b0;
    end
  end

  `QSLP_ASSERT_IMP(a_held_nonempty, cur_valid_q, cur_q.has_data || cur_q.has_verdict,
    "held event carries no beat")
  `QSLP_ASSERT_IMP(a_take_ready, take, !cur_valid_q || popped, "event loaded over live one")

endmodule

`default_nettype wire

// ----- hdl/quoted_string_list_parser.sv -----
// top level of the quoted string list parser
// depends on qslp_pkg, qslp_front, qslp_evq, qslp_back
//
// Usage:
//  Input side is a queue push port: a text byte (text_byte_i, final_req_i)
//  is taken on a clock edge with push high and full low. One byte per cycle
//  is accepted while the event queue has room.
//  Result side is a queue pop port: while empty is low the oldest result is
//  on kind_o / value_o / accepted_o / last_of_run_o and leaves on an edge
//  with pop high. Content bytes and string ends give one beat, the final or
//  zero byte adds a verdict beat, so a byte yields zero, one or two beats.
//  A result passes through the event queue and then the output register.
//  Throughput: one byte per cycle in while full is low, one beat per cycle
//  out while pop is high; the output register plus the QDepth-entry event
//  queue absorb receiver stalls, and full rises once the queue is full.
//  After a verdict every further byte is taken and dropped until reset.
//  Reset: asynchronous, active low; clears the parse state and the queue,
//  the block is ready in the first cycle after reset.
`default_nettype none

module quoted_string_list_parser import qslp_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output      logic       full,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       final_req_i,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [1:0] kind_o,
  output      logic [7:0] value_o,
  output      logic       accepted_o,
  output      logic       last_of_run_o
);

  event_t ev_wr_data, ev_rd_data;
  logic   ev_wr, q_full, q_valid, q_rd;

  // byte classification and parse state
  qslp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .text_byte_i (text_byte_i),
    .final_req_i (final_req_i),
    .q_full_i    (q_full),
    .full        (full),
    .ev_wr_o     (ev_wr),
    .ev_o        (ev_wr_data)
  );

  // decoupling queue
  qslp_evq #(
    .Depth (QDepth)
  ) u_evq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ev_wr),
    .wr_data_i (ev_wr_data),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (ev_rd_data)
  );

  // result beat generation
  qslp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (ev_rd_data),
    .q_rd_o        (q_rd),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .accepted_o    (accepted_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/quoted_string_list_parser_tb.sv -----
// self-checking testbench for the quoted string list parser: one list text is
// fed byte by byte and every result beat is checked against a local parser model
// depends on qslp_pkg and quoted_string_list_parser
`timescale 1ns / 100ps

module quoted_string_list_parser_tb;
  import qslp_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned ListBytes  = 800;
  localparam int unsigned DrainWait  = 20;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } text_byte_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] value;
    logic       acc;
    logic       last;
  } beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] text_byte   = 8'h00;
  logic       final_req   = 1'b0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [1:0] kind;
  logic [7:0] value;
  logic       accepted;
  logic       last_of_run;

  text_byte_t text_queue[$];
  beat_t      expected_beats[$];
  beat_t      want;
  text_byte_t nxt;
  logic       byte_accepted = 1'b0;
  logic       failed        = 1'b0;
  int unsigned n_taken      = 0;
  int unsigned cycles       = 0;
  logic       calm;

  // parser state of the local model
  mode_e      parse_st   = MODE_OPEN;
  logic       quote_dbl  = 1'b0;
  logic       esc_armed  = 1'b0;
  logic       text_done  = 1'b0;

  quoted_string_list_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte),
    .final_req_i   (final_req),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind),
    .value_o       (value),
    .accepted_o    (accepted),
    .last_of_run_o (last_of_run)
  );

  // no idling on either side while this window of bytes goes in
  assign calm = (n_taken >= 300) && (n_taken < 450);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic logic [7:0] pick_ws();
    return ($urandom_range(0, 2) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4));
  endfunction

  // plain content byte: nonzero, not the closing quote and not a backslash
  function automatic logic [7:0] pick_plain(input logic [7:0] quote);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == quote || c == ChEscape) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic fin);
    text_byte_t t;
    t.ch  = c;
    t.fin = fin;
    text_queue = {text_queue, t};
  endtask

  task automatic add_beat(ref beat_t run[$], input kind_e k, input logic [7:0] v,
                          input logic a);
    beat_t b;
    b.kind  = k;
    b.value = v;
    b.acc   = a;
    b.last  = 1'b0;
    run = {run, b};
  endtask

  // advance the local parser by one text byte and queue the beats it yields
  task automatic parse_byte(input logic [7:0] c, input logic fin);
    beat_t run[$];
    if (text_done) return;
    if (c != ChNul) begin
      case (parse_st)
        MODE_OPEN: begin
          if (c == ChOpen) parse_st = MODE_LIST;
          else if (!is_ws(c)) parse_st = MODE_REJECT;
        end
        MODE_LIST: begin
          if (c == ChClose) begin
            parse_st = MODE_CLOSED;
          end else if (c == ChSingle || c == ChDouble) begin
            parse_st  = MODE_STRING;
            quote_dbl = (c == ChDouble);
            esc_armed = 1'b0;
          end else if (c != ChComma && !is_ws(c)) begin
            parse_st = MODE_REJECT;
          end
        end
        MODE_STRING: begin
          if (esc_armed) begin
            esc_armed = 1'b0;
            add_beat(run, KIND_BYTE, c, 1'b0);
          end else if (c == ChEscape) begin
            esc_armed = 1'b1;
          end else if (c == (quote_dbl ? ChDouble : ChSingle)) begin
            parse_st = MODE_LIST;
            add_beat(run, KIND_END, 8'h00, 1'b0);
          end else begin
            add_beat(run, KIND_BYTE, c, 1'b0);
          end
        end
        MODE_CLOSED: begin
          if (!is_ws(c)) parse_st = MODE_REJECT;
        end
        default: parse_st = MODE_REJECT;
      endcase
    end
    if (c == ChNul || fin) begin
      add_beat(run, KIND_VERDICT, 8'h00, parse_st == MODE_CLOSED);
      text_done = 1'b1;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_beats = {expected_beats, run[i]};
  endtask

  // input driver: a beat holds until it is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || byte_accepted) begin
      if (text_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
        nxt = text_queue.pop_front();
        push      <= 1'b1;
        text_byte <= nxt.ch;
        final_req <= nxt.fin;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    pop <= rst_ni && (calm || $urandom_range(0, 99) >= 35);
  end

  // monitor: check result beats, then feed accepted bytes to the model
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_accepted = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: kind %0d value %0h", kind, value);
          failed = 1'b1;
        end else begin
          want = expected_beats.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            failed = 1'b1;
          end
          if (value !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, value);
            failed = 1'b1;
          end
          if (accepted !== want.acc) begin
            $error("accepted: expected %0b, got %0b", want.acc, accepted);
            failed = 1'b1;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
            failed = 1'b1;
          end
        end
      end
      byte_accepted = push && !full;
      if (byte_accepted) begin
        parse_byte(text_byte, final_req);
        n_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0] quote;
    int unsigned slen;
    int unsigned tail;
    // directed opening: every blank, commas, both quote kinds, escapes,
    // the other quote as content, byte extremes, an empty string
    add_byte(8'h20, 1'b0);
    add_byte(8'h09, 1'b0);
    add_byte(8'h0A, 1'b0);
    add_byte(8'h0B, 1'b0);
    add_byte(8'h0C, 1'b0);
    add_byte(8'h0D, 1'b0);
    add_byte(ChOpen, 1'b0);
    add_byte(ChComma, 1'b0);
    add_byte(ChComma, 1'b0);
    add_byte(ChSingle, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(ChDouble, 1'b0);
    add_byte(ChEscape, 1'b0);
    add_byte(ChSingle, 1'b0);
    add_byte(ChEscape, 1'b0);
    add_byte(ChEscape, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(ChSingle, 1'b0);
    add_byte(ChDouble, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(ChSingle, 1'b0);
    add_byte(ChDouble, 1'b0);
    add_byte(ChDouble, 1'b0);
    add_byte(ChDouble, 1'b0);

    // random body: separators then a string with random content
    while (text_queue.size() < ListBytes) begin
      repeat ($urandom_range(0, 3))
        add_byte(($urandom_range(0, 1) == 0) ? ChComma : pick_ws(), 1'b0);
      quote = ($urandom_range(0, 1) == 0) ? ChSingle : ChDouble;
      add_byte(quote, 1'b0);
      slen = $urandom_range(0, 12);
      repeat (slen) begin
        if ($urandom_range(0, 99) < 15) begin
          add_byte(ChEscape, 1'b0);
          add_byte(8'($urandom_range(1, 255)), 1'b0);
        end else begin
          add_byte(pick_plain(quote), 1'b0);
        end
      end
      add_byte(quote, 1'b0);
    end

    // ending of the text: accepted lists and broken ones
    tail = $urandom_range(0, 7);
    quote = ($urandom_range(0, 1) == 0) ? ChSingle : ChDouble;
    case (tail)
      0: add_byte(ChClose, 1'b1);
      1: begin
        add_byte(ChClose, 1'b0);
        repeat ($urandom_range(0, 4)) add_byte(pick_ws(), 1'b0);
        add_byte(pick_ws(), 1'b1);
      end
      2: begin
        add_byte(ChClose, 1'b0);
        add_byte(ChNul, 1'($urandom_range(0, 1)));
      end
      3: begin
        add_byte(quote, 1'b0);
        add_byte(pick_plain(quote), 1'b1);
      end
      4: begin
        add_byte(quote, 1'b0);
        add_byte(pick_plain(quote), 1'b0);
        add_byte(quote, 1'b1);
      end
      5: begin
        add_byte(ChClose, 1'b0);
        add_byte(8'h78, 1'b0);
        add_byte(pick_ws(), 1'b1);
      end
      6: begin
        // stray byte in the list, then noise that must stay silent
        add_byte(8'h41, 1'b0);
        repeat ($urandom_range(5, 30)) add_byte(8'($urandom_range(1, 255)), 1'b0);
        add_byte(ChNul, 1'b0);
      end
      default: begin
        add_byte(quote, 1'b0);
        add_byte(pick_plain(quote), 1'b0);
        add_byte(ChNul, 1'($urandom_range(0, 1)));
      end
    endcase

    // bytes after the verdict are taken and dropped
    repeat (10) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (text_queue.size() != 0 || push) @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
